/* sv/mse_pkg.sv */
// ----------------------------------------------------------------------------
// mse_pkg
// shared types and constants of the microwire serial eeprom
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int WORD_W      = 16;
	localparam int ADDR_W      = 8;
	localparam int BITPOS_W    = 5;
	localparam int CFG_W       = 9;
	localparam int ABITS_W     = 4;
	// start pair plus two opcode bits
	localparam int HEADER_BITS = 4;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t ERASED_WORD = 16'hffff;

	// configuration register indexes
	localparam logic [0:0] CFG_ADDRESS_BITS = 1'b0;
	localparam logic [0:0] CFG_WORD_COUNT   = 1'b1;

	localparam logic [ABITS_W-1:0] ABITS_RESET = 4'd6;
	localparam logic [CFG_W-1:0]   WORDS_RESET = 9'd64;

	typedef struct packed {
		logic              action;
		logic              chip_select;
		logic              serial_clock;
		logic              data_in;
		logic [ADDR_W-1:0] preload_address;
		word_t             preload_value;
	} in_item_t;

	typedef struct packed {
		logic data_out;
	} out_item_t;

endpackage

/* sv/mse_in_if.sv */
// ----------------------------------------------------------------------------
// mse_in_if
// pin sample / preload channel, valid-ready handshake
// ----------------------------------------------------------------------------
interface mse_in_if;
	logic              valid;
	logic              ready;
	mse_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/mse_out_if.sv */
// ----------------------------------------------------------------------------
// mse_out_if
// data out level channel, valid-ready handshake
// ----------------------------------------------------------------------------
interface mse_out_if;
	logic               valid;
	logic               ready;
	mse_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/microwire_serial_eeprom.sv */
// ----------------------------------------------------------------------------
// microwire_serial_eeprom
// plain pin samples and direct preloads: one beat per cycle unless the reply sink stalls, one reply beat each
// address-complete samples, erase and write commits, folded preloads: the remainder unit,
// then the action state, plus the read state after non-extended addresses and write commits
// erase all / write all: a sweep over the word memory; no new beat is taken until back in idle
// reset: control registers and per-word valid bits clear at once, no clearing pass
// ----------------------------------------------------------------------------
module microwire_serial_eeprom #(
	parameter int MAX_WORDS        = 256,
	parameter int MAX_ADDRESS_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [0:0]                cfg_index,
	input  logic [mse_pkg::CFG_W-1:0] cfg_data,
	mse_in_if.sink                    sample,
	mse_out_if.source                 reply
);

	localparam int IDX_W = $clog2(MAX_WORDS);
	localparam int CW    = mse_pkg::CFG_W;
	localparam int AW    = mse_pkg::ADDR_W;
	localparam int BW    = mse_pkg::BITPOS_W;
	localparam int ABW   = mse_pkg::ABITS_W;
	localparam int WW    = mse_pkg::WORD_W;

	localparam logic [CW-1:0]  MAX_WD   = CW'(MAX_WORDS);
	localparam logic [ABW-1:0] MAX_AB   = ABW'(MAX_ADDRESS_BITS);
	localparam logic [ABW-1:0] MIN_AB   = ABW'(2);
	localparam logic [BW-1:0]  HDR      = BW'(mse_pkg::HEADER_BITS);
	localparam logic [2:0]     MOD_LAST = 3'(AW - 1);

	// frame bit positions before the opcode
	localparam logic [BW-1:0] BP_FIRST  = BW'(0);
	localparam logic [BW-1:0] BP_SECOND = BW'(1);
	localparam logic [BW-1:0] BP_OPCODE = BW'(2);

	// command opcodes and extended subcommands
	typedef enum logic [1:0] {
		OPC_EXT   = 2'd0,
		OPC_WRITE = 2'd1,
		OPC_READ  = 2'd2,
		OPC_ERASE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		SUB_WDS  = 2'd0,
		SUB_WRAL = 2'd1,
		SUB_ERAL = 2'd2,
		SUB_WEN  = 2'd3
	} subop_t;

	// what to do once the remainder unit has reduced an address
	typedef enum logic [1:0] {
		OP_FETCH,
		OP_ERASE,
		OP_WRITE,
		OP_PRELOAD
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_ACT,
		ST_RD,
		ST_SWEEP
	} state_t;

	// ------------------------------------------------------------------
	// configuration registers and their clamped views
	// ------------------------------------------------------------------
	logic [ABW-1:0] abits_q;
	logic [CW-1:0]  words_q;
	logic [ABW-1:0] abits_eff;
	logic [CW-1:0]  words_eff;
	logic [BW-1:0]  addr_end;
	logic [BW-1:0]  data_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abits_q <= mse_pkg::ABITS_RESET;
			words_q <= mse_pkg::WORDS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mse_pkg::CFG_ADDRESS_BITS: abits_q <= cfg_data[ABW-1:0];
				mse_pkg::CFG_WORD_COUNT:   words_q <= cfg_data;
				default:                   ;
			endcase
		end
	end

	always_comb begin
		if (abits_q < MIN_AB)
			abits_eff = MIN_AB;
		else if (abits_q > MAX_AB)
			abits_eff = MAX_AB;
		else
			abits_eff = abits_q;
		if (words_q == '0)
			words_eff = CW'(1);
		else if (words_q > MAX_WD)
			words_eff = MAX_WD;
		else
			words_eff = words_q;
	end

	// positions one past the last address bit and one past the last data bit of a frame
	assign addr_end = HDR + BW'(abits_eff);
	assign data_end = addr_end + BW'(WW);

	// ------------------------------------------------------------------
	// device state
	// ------------------------------------------------------------------
	state_t          state_q;
	op_t             op_q;
	logic            last_sel_q;
	logic            last_clk_q;
	logic            out_bit_q;
	logic [BW-1:0]   bit_pos_q;
	opcode_t         opcode_q;
	logic [AW-1:0]   addr_shift_q;
	subop_t          sub_q;
	logic            wr_en_q;
	mse_pkg::word_t  data_shift_q;
	mse_pkg::word_t  pl_value_q;

	// remainder unit: one restoring step per cycle
	logic [AW-1:0]   mod_dvd_q;
	logic [AW-1:0]   mod_rem_q;
	logic [CW-1:0]   mod_div_q;
	logic [2:0]      mod_cnt_q;
	logic [CW-1:0]   mod_trial;
	logic [AW-1:0]   mod_rem_n;

	// sweep for erase all / write all
	logic [CW-1:0]   sweep_cnt_q;
	logic            sweep_erase_q;
	logic            wr_vld_s1;
	logic [IDX_W-1:0] wr_addr_s1;

	// reply register
	logic            reply_vld_q;
	logic            out_data_q;
	logic            pending_q;
	logic            out_free;
	logic            acc;

	// word memory with per-word valid bits (unwritten words read as zero)
	mse_pkg::word_t  mem [MAX_WORDS];
	logic [MAX_WORDS-1:0] valid_q;
	mse_pkg::word_t  rd_data_q;
	logic            rd_vld_q;
	mse_pkg::word_t  rd_word;
	logic            mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_ra;
	mse_pkg::word_t  mem_wd;
	logic [IDX_W-1:0] rem_idx;

	// handshake
	assign sample.ready          = (state_q == ST_IDLE) && !pending_q;
	assign acc                   = sample.valid && sample.ready;
	assign reply.valid           = reply_vld_q;
	assign reply.payload.data_out = out_data_q;
	assign out_free              = !reply_vld_q || reply.ready;

	assign rem_idx = mod_rem_q[IDX_W-1:0];
	assign rd_word = rd_vld_q ? rd_data_q : '0;

	// one restoring remainder step
	assign mod_trial = {mod_rem_q, mod_dvd_q[AW-1]};
	assign mod_rem_n = (mod_trial >= mod_div_q) ? AW'(mod_trial - mod_div_q)
		: mod_trial[AW-1:0];

	// ------------------------------------------------------------------
	// next state for an accepted beat
	// ------------------------------------------------------------------
	logic            direct_pl;
	logic            ls_n;
	logic            lc_n;
	logic            ob_n;
	logic [BW-1:0]   bp_n;
	logic [BW-1:0]   bp_inc;
	opcode_t         opc_n;
	logic [AW-1:0]   ash_n;
	subop_t          sub_n;
	logic            wen_n;
	mse_pkg::word_t  ds_n;
	logic            go_mod;
	logic [AW-1:0]   mod_dvd_n;
	logic [CW-1:0]   mod_div_n;
	op_t             op_n;
	logic            go_sweep;
	logic            sweep_erase_n;
	logic [2:0]      sub_sh;

	assign direct_pl = {1'b0, sample.payload.preload_address} < MAX_WD;
	assign bp_inc    = bit_pos_q + BW'(1);
	assign sub_sh    = 3'(abits_eff - MIN_AB);

	always_comb begin
		ls_n          = last_sel_q;
		lc_n          = last_clk_q;
		ob_n          = out_bit_q;
		bp_n          = bit_pos_q;
		opc_n         = opcode_q;
		ash_n         = addr_shift_q;
		sub_n         = sub_q;
		wen_n         = wr_en_q;
		ds_n          = data_shift_q;
		go_mod        = 1'b0;
		mod_dvd_n     = addr_shift_q;
		mod_div_n     = words_eff;
		op_n          = OP_FETCH;
		go_sweep      = 1'b0;
		sweep_erase_n = 1'b0;
		if (sample.payload.action) begin
			// preload beyond the memory depth is folded by the remainder unit
			if (!direct_pl) begin
				go_mod    = 1'b1;
				mod_dvd_n = sample.payload.preload_address;
				mod_div_n = MAX_WD;
				op_n      = OP_PRELOAD;
			end
		end else begin
			ls_n = sample.payload.chip_select;
			lc_n = sample.payload.serial_clock;
			if (!last_sel_q && sample.payload.chip_select) begin
				// frame start
				bp_n  = '0;
				opc_n = OPC_EXT;
				ash_n = '0;
				sub_n = SUB_WDS;
			end else if (last_sel_q && !sample.payload.chip_select) begin
				// frame end: commit if writes are enabled
				ob_n = 1'b1;
				if (wr_en_q) begin
					if (opcode_q == OPC_EXT && sub_q == SUB_ERAL) begin
						go_sweep      = 1'b1;
						sweep_erase_n = 1'b1;
					end else if (opcode_q == OPC_ERASE) begin
						go_mod = 1'b1;
						op_n   = OP_ERASE;
					end else if (bit_pos_q >= data_end) begin
						if (opcode_q == OPC_WRITE) begin
							go_mod = 1'b1;
							op_n   = OP_WRITE;
						end else if (opcode_q == OPC_EXT && sub_q == SUB_WRAL) begin
							go_sweep = 1'b1;
						end
					end
				end
			end else if (sample.payload.chip_select && !last_clk_q
				&& sample.payload.serial_clock) begin
				// rising serial clock inside a frame
				if (bit_pos_q == BP_FIRST) begin
					// a 1 here skips the second start bit
					bp_n = sample.payload.data_in ? BP_OPCODE : BP_SECOND;
				end else if (bit_pos_q == BP_SECOND) begin
					if (sample.payload.data_in)
						bp_n = BP_OPCODE;
				end else if (bit_pos_q < HDR) begin
					bp_n  = bp_inc;
					opc_n = opcode_t'({opcode_q[0], sample.payload.data_in});
				end else if (bit_pos_q < addr_end) begin
					bp_n  = bp_inc;
					ash_n = {addr_shift_q[AW-2:0], sample.payload.data_in};
					if (bp_inc == addr_end) begin
						// address complete: decode subcommand from the raw bits
						if (opcode_q == OPC_READ)
							ob_n = 1'b0;
						sub_n = subop_t'(2'(ash_n >> sub_sh));
						if (opcode_q == OPC_EXT) begin
							if (sub_n == SUB_WDS)
								wen_n = 1'b0;
							else if (sub_n == SUB_WEN)
								wen_n = 1'b1;
						end
						go_mod    = 1'b1;
						mod_dvd_n = ash_n;
						op_n      = OP_FETCH;
					end
				end else if (bit_pos_q < data_end) begin
					bp_n = bp_inc;
					if (opcode_q == OPC_READ)
						ob_n = data_shift_q[WW-1];
					ds_n = {data_shift_q[WW-2:0], sample.payload.data_in};
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequencer and registered reply
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_FETCH;
			last_sel_q    <= 1'b0;
			last_clk_q    <= 1'b0;
			out_bit_q     <= 1'b1;
			bit_pos_q     <= '0;
			opcode_q      <= OPC_EXT;
			addr_shift_q  <= '0;
			sub_q         <= SUB_WDS;
			wr_en_q       <= 1'b0;
			data_shift_q  <= '0;
			pl_value_q    <= '0;
			mod_dvd_q     <= '0;
			mod_rem_q     <= '0;
			mod_div_q     <= CW'(1);
			mod_cnt_q     <= '0;
			sweep_cnt_q   <= '0;
			sweep_erase_q <= 1'b0;
			wr_vld_s1     <= 1'b0;
			wr_addr_s1    <= '0;
			reply_vld_q   <= 1'b0;
			out_data_q    <= 1'b1;
			pending_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						last_sel_q   <= ls_n;
						last_clk_q   <= lc_n;
						out_bit_q    <= ob_n;
						bit_pos_q    <= bp_n;
						opcode_q     <= opc_n;
						addr_shift_q <= ash_n;
						sub_q        <= sub_n;
						wr_en_q      <= wen_n;
						data_shift_q <= ds_n;
						pl_value_q   <= sample.payload.preload_value;
						if (go_mod) begin
							mod_dvd_q <= mod_dvd_n;
							mod_div_q <= mod_div_n;
							mod_rem_q <= '0;
							mod_cnt_q <= '0;
							op_q      <= op_n;
							state_q   <= ST_MOD;
						end else if (go_sweep) begin
							sweep_cnt_q   <= '0;
							sweep_erase_q <= sweep_erase_n;
							wr_vld_s1     <= 1'b0;
							state_q       <= ST_SWEEP;
						end
					end
				end
				ST_MOD: begin
					mod_rem_q <= mod_rem_n;
					mod_dvd_q <= {mod_dvd_q[AW-2:0], 1'b0};
					mod_cnt_q <= mod_cnt_q + 3'd1;
					if (mod_cnt_q == MOD_LAST)
						state_q <= ST_ACT;
				end
				ST_ACT: begin
					// memory read or write at the reduced address is issued here
					case (op_q)
						OP_FETCH: begin
							addr_shift_q <= mod_rem_q;
							state_q      <= (opcode_q != OPC_EXT) ? ST_RD : ST_IDLE;
						end
						OP_WRITE: state_q <= ST_RD;
						default:  state_q <= ST_IDLE;
					endcase
				end
				ST_RD: begin
					if (op_q == OP_FETCH)
						data_shift_q <= rd_word;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					// read word n while word n-1 is written back
					if (sweep_cnt_q < words_eff) begin
						sweep_cnt_q <= sweep_cnt_q + CW'(1);
						wr_vld_s1   <= 1'b1;
						wr_addr_s1  <= sweep_cnt_q[IDX_W-1:0];
					end else begin
						wr_vld_s1 <= 1'b0;
						if (!wr_vld_s1)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// reply beat: the level after the step, held back while the sink stalls
			if (acc) begin
				if (out_free) begin
					reply_vld_q <= 1'b1;
					out_data_q  <= ob_n;
				end else begin
					pending_q <= 1'b1;
				end
			end else if (pending_q && out_free) begin
				reply_vld_q <= 1'b1;
				out_data_q  <= out_bit_q;
				pending_q   <= 1'b0;
			end else if (reply.ready) begin
				reply_vld_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// memory port steering
	// ------------------------------------------------------------------
	always_comb begin
		mem_we = 1'b0;
		mem_wa = rem_idx;
		mem_ra = rem_idx;
		mem_wd = mse_pkg::ERASED_WORD;
		case (state_q)
			ST_IDLE: begin
				if (acc && sample.payload.action && direct_pl) begin
					mem_we = 1'b1;
					mem_wa = sample.payload.preload_address[IDX_W-1:0];
					mem_wd = sample.payload.preload_value;
				end
			end
			ST_ACT: begin
				if (op_q == OP_ERASE) begin
					mem_we = 1'b1;
				end else if (op_q == OP_PRELOAD) begin
					mem_we = 1'b1;
					mem_wd = pl_value_q;
				end
			end
			ST_RD: begin
				if (op_q == OP_WRITE) begin
					mem_we = 1'b1;
					mem_wd = rd_word & data_shift_q;
				end
			end
			ST_SWEEP: begin
				mem_ra = sweep_cnt_q[IDX_W-1:0];
				if (wr_vld_s1) begin
					mem_we = 1'b1;
					mem_wa = wr_addr_s1;
					mem_wd = sweep_erase_q ? mse_pkg::ERASED_WORD : (rd_word & data_shift_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we)
				valid_q[mem_wa] <= 1'b1;
			rd_vld_q <= valid_q[mem_ra];
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// a held-back reply only exists behind an occupied reply register
	a_pending_full: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> reply_vld_q)
		else $error("pending reply without a full reply register");

	// the remainder unit moves to the action state after its last step
	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD && mod_cnt_q == MOD_LAST) |=> (state_q == ST_ACT))
		else $error("remainder unit did not finish");

	// a reduced address is below its divisor
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACT) |-> ({1'b0, mod_rem_q} < mod_div_q))
		else $error("remainder out of range");

	// the sweep never runs past the words in use
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (sweep_cnt_q <= words_eff))
		else $error("sweep counter past word count");
`endif

endmodule
